>>> design/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, checked during reset too.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/nstd_pkg.sv
// Package: types and constants of the note step table.
`timescale 1ns / 1ps
package nstd_pkg;
  localparam int SLOTS     = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int NOTE_LIFE = 12;
  localparam int PCT_W     = 7;
  localparam int PERIOD_W  = 16;
  localparam int TIME_W    = 32;
  localparam int LIM_W     = CNT_W + PCT_W + 1;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_PLAY  = 2'd1;
  localparam logic [1:0] ACT_LEARN = 2'd2;

  localparam logic CFG_STEP_PERIOD  = 1'b0;
  localparam logic CFG_FILL_PERCENT = 1'b1;

  typedef struct packed {
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] length;
    logic [3:0]  channel;
    logic [3:0]  life;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } state_t;
endpackage

>>> design/nstd_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module nstd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/nstd_div.sv
// Serial restoring divider: time stamp by step period, one bit per cycle.
`timescale 1ns / 1ps
module nstd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [nstd_pkg::TIME_W-1:0]   dividend,
  input  logic [nstd_pkg::PERIOD_W-1:0] divisor,
  output logic                          done,
  output logic [nstd_pkg::TIME_W-1:0]   quotient
);
  import nstd_pkg::*;

  localparam int STEP_W = $clog2(TIME_W);

  logic                busy;
  logic [STEP_W-1:0]   cnt;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W-1:0] dvs;
  logic [TIME_W-1:0]   quo;
  logic [PERIOD_W:0]   shifted;
  logic                fits;

  assign shifted  = {rem, quo[TIME_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(TIME_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(TIME_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= PERIOD_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[PERIOD_W-1:0];
      end
      quo <= {quo[TIME_W-2:0], fits};
    end
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_no_restart, busy |-> !start, "divider restarted while busy")
  `ASSERT_CLK(a_rem_bound, busy |-> rem < dvs, "partial remainder not below divisor")
endmodule

>>> design/note_step_table_with_decay_top.sv
// Top level: looping note step table with decaying life counts.
`timescale 1ns / 1ps
// Each item that is not ignored takes a serial 32-bit division of time_now by
// the step period (one quotient bit per cycle) to find its slot, then a read
// of the slot memory and, where a note is kept, a write-back. An add that puts
// the table over its fill limit then scans the other slots' occupancy flags one
// slot per cycle for a note to evict. Ignored items (unknown action, zero
// velocity add, rate-limited play) skip the division and the memory access.
// The result register lets a new item in while a played note waits to be taken.
// No clearing pass follows reset: per-slot occupancy flags are cleared at once.
module note_step_table_with_decay_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [nstd_pkg::PERIOD_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [31:0]                   time_now,
  input  logic [6:0]                    note_number,
  input  logic [6:0]                    note_velocity,
  input  logic [15:0]                   note_length,
  input  logic [3:0]                    midi_channel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [6:0]                    out_note,
  output logic [6:0]                    out_velocity,
  output logic [15:0]                   out_length,
  output logic [3:0]                    out_channel,
  output logic [3:0]                    out_life
);
  import nstd_pkg::*;

  state_t state, state_next;

  logic [PERIOD_W-1:0] step_period;
  logic [PCT_W-1:0]    fill_percent;
  logic [TIME_W-1:0]   last_play;
  logic [CNT_W-1:0]    count;
  logic [SLOTS-1:0]    occ;
  logic [SLOT_W-1:0]   pos;
  logic [SLOT_W-1:0]   idx;
  logic [1:0]          act;
  entry_t              new_entry;
  entry_t              res;

  logic [PERIOD_W-1:0] eff_period;
  logic                accept;
  logic                rate_ok;
  logic                go;
  logic                div_done;
  logic [TIME_W-1:0]   div_quo;
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;
  entry_t              dec_entry;
  logic [CNT_W-1:0]    count_add;
  logic                over;
  logic                out_free;

  assign eff_period = (step_period == '0) ? PERIOD_W'(1) : step_period;
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign rate_ok    = (time_now - last_play) >= TIME_W'(eff_period);
  assign go         = accept && (((action == ACT_ADD) && (note_velocity != '0))
                      || ((action == ACT_PLAY) && rate_ok) || (action == ACT_LEARN));
  assign out_free   = !out_valid || !out_stall;

  assign rd_entry  = entry_t'(ram_rdata);
  assign count_add = occ[pos] ? count : count + 1'b1;
  assign over      = (LIM_W'(count_add) * LIM_W'(100)) > (LIM_W'(fill_percent) << SLOT_W);

  always_comb begin
    dec_entry      = rd_entry;
    dec_entry.life = rd_entry.life - 1'b1;
  end

  assign ram_addr  = (state == S_DIV) ? div_quo[SLOT_W-1:0] : pos;
  assign ram_we    = (state == S_EXEC) &&
                     ((act == ACT_ADD) || (occ[pos] && (dec_entry.life != '0)));
  assign ram_wdata = (act == ACT_ADD) ? ENTRY_W'(new_entry) : ENTRY_W'(dec_entry);

  nstd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (go),
    .dividend (time_now),
    .divisor  (eff_period),
    .done     (div_done),
    .quotient (div_quo)
  );

  nstd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (go) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (act == ACT_ADD) begin
          state_next = over ? S_SCAN : S_IDLE;
        end else begin
          state_next = occ[pos] ? S_EMIT : S_IDLE;
        end
      end
      S_SCAN: begin
        if ((idx == pos) || occ[idx]) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period  <= PERIOD_W'(100);
      fill_percent <= PCT_W'(50);
      last_play    <= '0;
      count        <= '0;
      occ          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_PERIOD:  step_period <= cfg_data;
          CFG_FILL_PERCENT: fill_percent <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (go && (action == ACT_PLAY)) begin
        last_play <= time_now;
      end
      if ((state == S_EXEC) && (act == ACT_ADD)) begin
        occ[pos] <= 1'b1;
        count    <= count_add;
      end else if ((state == S_EXEC) && occ[pos] && (dec_entry.life == '0)) begin
        occ[pos] <= 1'b0;
        count    <= count - 1'b1;
      end else if ((state == S_SCAN) && (idx != pos) && occ[idx]) begin
        occ[idx] <= 1'b0;
        count    <= count - 1'b1;
      end
      if ((state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      act                <= action;
      new_entry.note     <= note_number;
      new_entry.velocity <= note_velocity;
      new_entry.length   <= note_length;
      new_entry.channel  <= midi_channel;
      new_entry.life     <= 4'(NOTE_LIFE);
    end
    if (div_done) begin
      pos <= div_quo[SLOT_W-1:0];
    end
    if (state == S_EXEC) begin
      idx <= pos + 1'b1;
      res <= rd_entry;
    end else if (state == S_SCAN) begin
      idx <= idx + 1'b1;
    end
    if ((state == S_EMIT) && out_free) begin
      out_note     <= res.note;
      out_velocity <= res.velocity;
      out_length   <= res.length;
      out_channel  <= res.channel;
      out_life     <= res.life;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_count_matches, count == CNT_W'($countones(occ)),
              "occupied count out of step with occupancy flags")
  `ASSERT_CLK(a_done_in_div, div_done |-> state == S_DIV,
              "divider finished outside the divide state")
  `ASSERT_CLK(a_scan_over, (state == S_SCAN) |->
              (LIM_W'(count) * LIM_W'(100)) > (LIM_W'(fill_percent) << SLOT_W),
              "eviction scan while under the fill limit")
endmodule

>>> tb/note_step_table_with_decay_top_tb.sv
// Testbench for the note step table: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module note_step_table_with_decay_top_tb;
  import nstd_pkg::*;

  typedef struct packed {
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] length;
    logic [3:0]  channel;
    logic [3:0]  life;
  } play_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [PERIOD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [31:0] time_now = '0;
  logic [6:0] note_number = '0;
  logic [6:0] note_velocity = '0;
  logic [15:0] note_length = '0;
  logic [3:0] midi_channel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [6:0] out_note;
  logic [6:0] out_velocity;
  logic [15:0] out_length;
  logic [3:0] out_channel;
  logic [3:0] out_life;

  note_step_table_with_decay_top dut (.*);

  entry_t table_model [SLOTS];
  int unsigned occupied;
  logic [31:0] last_play;
  logic [15:0] period_reg;
  logic [6:0] fill_reg;
  play_t played_q[$];
  int errors = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit hold_off = 1'b0;
  int stall_left = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned slot_of(logic [31:0] t);
    logic [31:0] p;
    p = (period_reg == 0) ? 32'd1 : {16'd0, period_reg};
    return (t / p) % SLOTS;
  endfunction

  function automatic bit evict_range(int unsigned lo, int unsigned hi);
    for (int unsigned i = lo; i < hi; i++)
      if (table_model[i].velocity != 0) begin
        table_model[i].velocity = '0;
        occupied--;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  task automatic predict_play(logic [31:0] t);
    int unsigned pos;
    play_t r;
    pos = slot_of(t);
    if (table_model[pos].velocity == 0) return;
    r.note = table_model[pos].note;
    r.velocity = table_model[pos].velocity;
    r.length = table_model[pos].length;
    r.channel = table_model[pos].channel;
    r.life = table_model[pos].life;
    played_q.push_back(r);
    table_model[pos].life = table_model[pos].life - 1;
    if (table_model[pos].life == 0) begin
      table_model[pos].velocity = '0;
      occupied--;
    end
  endtask

  task automatic predict_item(logic [1:0] a, logic [31:0] t, logic [6:0] n,
                              logic [6:0] v, logic [15:0] l, logic [3:0] c);
    int unsigned pos;
    int unsigned lim;
    logic [31:0] p;
    p = (period_reg == 0) ? 32'd1 : {16'd0, period_reg};
    case (a)
      ACT_ADD: begin
        if (v == 0) return;
        pos = slot_of(t);
        if (table_model[pos].velocity == 0) occupied++;
        table_model[pos] = '{note: n, velocity: v, length: l, channel: c,
                             life: 4'(NOTE_LIFE)};
        lim = (SLOTS * fill_reg) / 100;
        if (occupied > lim)
          if (!evict_range(pos + 1, SLOTS)) void'(evict_range(0, pos));
      end
      ACT_PLAY: begin
        if (t - last_play < p) return;
        last_play = t;
        predict_play(t);
      end
      ACT_LEARN: predict_play(t);
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] a, logic [31:0] t, logic [6:0] n,
                           logic [6:0] v, logic [15:0] l, logic [3:0] c);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    time_now <= t;
    note_number <= n;
    note_velocity <= v;
    note_length <= l;
    midi_channel <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(a, t, n, v, l, c);
  endtask

  task automatic drain_and_settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (played_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STEP_PERIOD) period_reg = val;
    else fill_reg = val[6:0];
  endtask

  function automatic logic [31:0] time_at(int unsigned slot);
    logic [31:0] p;
    p = (period_reg == 0) ? 32'd1 : {16'd0, period_reg};
    return slot * p + $urandom_range(0, p - 1);
  endfunction

  task automatic test_directed();
    send_item(ACT_ADD, 32'd0, 7'd0, 7'd127, 16'hFFFF, 4'hF);
    send_item(ACT_ADD, 32'hFFFF_FFFF, 7'd127, 7'd1, 16'd0, 4'd0);
    send_item(ACT_ADD, 32'd150, 7'd60, 7'd0, 16'd5, 4'd3);
    send_item(ACT_LEARN, 32'd0, '0, '0, '0, '0);
    send_item(ACT_PLAY, 32'd50, '0, '0, '0, '0);
    send_item(ACT_PLAY, 32'd100, '0, '0, '0, '0);
    send_item(ACT_PLAY, 32'hFFFF_FFFF, '0, '0, '0, '0);
    send_item(2'd3, 32'd0, 7'd5, 7'd5, 16'd5, 4'd5);
    for (int i = 0; i < 12; i++) send_item(ACT_LEARN, 32'd10, '0, '0, '0, '0);
    send_item(ACT_LEARN, 32'd10, '0, '0, '0, '0);
  endtask

  task automatic test_zero_period_and_fill();
    write_cfg(CFG_STEP_PERIOD, 16'd0);
    write_cfg(CFG_FILL_PERCENT, 16'd0);
    for (int i = 0; i < 6; i++)
      send_item(ACT_ADD, 32'(i * 7), 7'(i), 7'd9, 16'(i), 4'(i));
    send_item(ACT_LEARN, 32'd35, '0, '0, '0, '0);
    send_item(ACT_PLAY, 32'd7, '0, '0, '0, '0);
    write_cfg(CFG_FILL_PERCENT, 16'd127);
    write_cfg(CFG_STEP_PERIOD, 16'hFFFF);
    send_item(ACT_ADD, 32'hFFFF_FFFF, 7'd1, 7'd2, 16'd3, 4'd4);
    send_item(ACT_LEARN, 32'hFFFF_FFFF, '0, '0, '0, '0);
  endtask

  task automatic random_phase(int count, bit idle_on);
    logic [1:0] a;
    logic [31:0] t;
    send_idle = idle_on;
    recv_idle = idle_on;
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(0, 9) < 5 ? ACT_ADD : 2'($urandom_range(1, 3));
      t = ($urandom_range(0, 9) == 0) ? $urandom : time_at($urandom_range(0, 15));
      send_item(a, t, 7'($urandom), ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom),
                16'($urandom), 4'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_item(ACT_ADD, time_at(0), 7'd20, 7'd30, 16'd40, 4'd1);
        send_item(ACT_ADD, time_at(1), 7'd21, 7'd31, 16'd41, 4'd2);
        for (int i = 0; i < 8; i++)
          send_item(ACT_LEARN, time_at(i % 2), '0, '0, '0, '0);
      end
    join
  endtask

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (recv_idle && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 16);
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    play_t x;
    if (!rst && out_valid && !out_stall) begin
      if (played_q.size() == 0) begin
        $error("result with no expectation");
        errors++;
      end else begin
        x = played_q.pop_front();
        if (out_note !== x.note) begin
          $error("out_note exp %0d got %0d", x.note, out_note); errors++;
        end
        if (out_velocity !== x.velocity) begin
          $error("out_velocity exp %0d got %0d", x.velocity, out_velocity); errors++;
        end
        if (out_length !== x.length) begin
          $error("out_length exp %0d got %0d", x.length, out_length); errors++;
        end
        if (out_channel !== x.channel) begin
          $error("out_channel exp %0d got %0d", x.channel, out_channel); errors++;
        end
        if (out_life !== x.life) begin
          $error("out_life exp %0d got %0d", x.life, out_life); errors++;
        end
      end
    end
  end

  initial begin
    foreach (table_model[i]) table_model[i] = '0;
    occupied = 0;
    last_play = '0;
    period_reg = 16'd100;
    fill_reg = 7'd50;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_period_and_fill();
    write_cfg(CFG_STEP_PERIOD, 16'd1);
    write_cfg(CFG_FILL_PERCENT, 16'd100);
    random_phase(120, 1'b1);
    test_backpressure();
    write_cfg(CFG_STEP_PERIOD, 16'd37);
    write_cfg(CFG_FILL_PERCENT, 16'd10);
    random_phase(150, 1'b1);
    write_cfg(CFG_STEP_PERIOD, 16'd100);
    write_cfg(CFG_FILL_PERCENT, 16'd50);
    random_phase(130, 1'b0);
    drain_and_settle();
    if (errors == 0 && played_q.size() == 0) $display("Regression PASS");
    else begin
      if (played_q.size() != 0) $error("%0d results never came", played_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
